// ===== rtl/core/fbsv_pkg.sv =====
// Shared constants, types and helpers for the FSK bit slicer with variance timing.
// No dependencies; the top level fsk_bit_slicer_variance_timing refers to this package by scoped name.
package fbsv_pkg;

  localparam int MAX_SPS_DEF = 64;
  localparam int VAR_WIN_DEF = 100;
  localparam int VOL_WIN_DEF = 100;
  localparam longint VAR_LIMIT = 5000000;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [6:0] SPS_RESET = 7'd40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INV = 1'b1;

  // Timing adjustment codes
  localparam logic [1:0] ADJ_NONE   = 2'd0;
  localparam logic [1:0] ADJ_SKIP   = 2'd1;
  localparam logic [1:0] ADJ_REPEAT = 2'd2;

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_TAKE  = 14'h0002,
    S_VRD   = 14'h0004,
    S_VSQ   = 14'h0008,
    S_VACC  = 14'h0010,
    S_VSS   = 14'h0020,
    S_VVAR  = 14'h0040,
    S_VFIN  = 14'h0080,
    S_VOLW  = 14'h0100,
    S_MM    = 14'h0200,
    S_ML    = 14'h0400,
    S_MR    = 14'h0800,
    S_DEC   = 14'h1000,
    S_FLUSH = 14'h2000
  } state_t;

  // Floor of x/3 by reciprocal multiply; exact for x below 1024.
  function automatic logic [10:0] div3(input logic [10:0] x);
    logic [21:0] prod;
    prod = 22'(x) * 22'd683;
    return prod[21:11];
  endfunction

endpackage

// ===== rtl/core/fbsv_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module fbsv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fbsv_mul.sv =====
// Shared signed multiplier with a registered product, reused by the variance and decision steps of the sequencer.
// No dependencies.
module fbsv_mul #(
  parameter int MW = 25
) (
  input  logic                   clk,
  input  logic signed [MW-1:0]   a,
  input  logic signed [MW-1:0]   b,
  output logic signed [2*MW-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/core/fsk_bit_slicer_variance_timing.sv =====
// FSK symbol slicer with minimum-variance timing recovery: top level and sequencer.
// Depends on fbsv_pkg, fbsv_ram (phase and volume stores) and fbsv_mul (shared multiplier).
//
// Usage:
//   Samples enter on sample/sample_valid; the block raises sample_stall while it works
//   on a beat. One bit per symbol leaves on bit_res/bit_valid, held in an output
//   register until taken (bit_stall low). cfg_index/cfg_data/cfg_valid write the
//   symbol length (index 0) and invert_bits (index 1); cfg_ready is always high
//   and the user makes writes only while the block is idle; the block does not enforce it.
// Steps:
//   A sample inside a symbol is accepted, accumulated and finished. A sample that
//   closes a symbol adds a write plus a min/max sweep over the volume store, one entry a
//   cycle, then two passes through the shared multiplier. Every VARIANCE_WINDOW_SYMBOLS
//   symbols a variance sweep runs first, paced by the single read port of the phase
//   store and the one multiplier. A skipped sample is only remembered; a repeated one
//   makes two takes. The bit is decided in the decision step and waits in the flush step
//   until the output register takes it.
// Reset (rst, synchronous): clears the sample, symbol and volume counters, the symbol sums
//   and the pending adjustment, empties the volume window by a fill count (unfilled entries
//   read as zero), restores the registers to 40 and 0. No clearing pass is needed.
// Stall: a finished bit waits in the flush step while the output register is full and
//   stalled; the output register holds its beat until taken.
module fsk_bit_slicer_variance_timing #(
  parameter int MAX_SAMPLES_PER_SYMBOL  = fbsv_pkg::MAX_SPS_DEF,
  parameter int VARIANCE_WINDOW_SYMBOLS = fbsv_pkg::VAR_WIN_DEF,
  parameter int VOLUME_WINDOW_SYMBOLS   = fbsv_pkg::VOL_WIN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbsv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbsv_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [fbsv_pkg::SAMPLE_W-1:0] sample,
  output logic                                bit_valid,
  input  logic                                bit_stall,
  output logic                                bit_res
);

  localparam int MAXS   = MAX_SAMPLES_PER_SYMBOL;
  localparam int VW     = VARIANCE_WINDOW_SYMBOLS;
  localparam int LW     = VOLUME_WINDOW_SYMBOLS;
  localparam int SPS_W  = $clog2(MAXS + 1);
  localparam int IDX_W  = $clog2(MAXS);
  localparam int SUM_W  = 16 + $clog2(MAXS);
  localparam int SC_W   = $clog2(VW);
  localparam int VI_W   = $clog2(LW);
  localparam int FILL_W = $clog2(LW + 1);
  localparam int S_W    = 16 + $clog2(VW);
  localparam int Q_W    = 31 + $clog2(VW);
  localparam int MW0    = (SUM_W + 1 > S_W) ? SUM_W + 1 : S_W;
  localparam int MW     = (MW0 > SPS_W + 2) ? MW0 : SPS_W + 2;
  localparam int PW     = 2 * MW;
  localparam int PA_DEPTH = VW * MAXS;
  localparam int PA_W   = $clog2(PA_DEPTH);
  localparam logic signed [PW-1:0] LIMIT =
    PW'(64'(fbsv_pkg::VAR_LIMIT) * 64'(VW) * 64'(VW));

  fbsv_pkg::state_t state;

  // Configuration and model state
  logic [6:0]              sps_reg;
  logic                    inv_reg;
  logic [1:0]              pending;
  logic signed [15:0]      prev_sample;
  logic signed [15:0]      cur;
  logic signed [15:0]      second;
  logic                    two_take;
  logic                    has_res;
  logic                    res_bit;
  logic [IDX_W-1:0]        sample_index;
  logic [SC_W-1:0]         symbol_count;
  logic signed [SUM_W-1:0] middle_sum;
  logic signed [SUM_W-1:0] symbol_sum;
  logic [VI_W-1:0]         vol_index;
  logic [FILL_W-1:0]       vol_fill;

  // Variance sweep
  logic [IDX_W-1:0]        ph_i;
  logic [SC_W-1:0]         row_k;
  logic signed [S_W-1:0]   acc_s;
  logic [Q_W-1:0]          acc_q;
  logic signed [PW-1:0]    wq;
  logic signed [PW-1:0]    vmin_v;
  logic [IDX_W-1:0]        best_phase;

  // Volume min/max sweep and decision
  logic [VI_W:0]           mm_cnt;
  logic                    mm_rv;
  logic [VI_W-1:0]         mm_ridx;
  logic signed [SUM_W-1:0] vmin;
  logic signed [SUM_W-1:0] vmax;
  logic signed [PW-1:0]    lhs;

  // Combinational helpers
  logic [SPS_W-1:0]        sps_eff;
  logic [10:0]             sps11;
  logic [10:0]             lo11;
  logic [10:0]             hi11;
  logic [10:0]             idx11;
  logic                    sym_end;
  logic signed [SUM_W-1:0] middle_sum_next;
  logic signed [SUM_W-1:0] symbol_sum_next;
  logic signed [PW-1:0]    v_cur;
  logic signed [SUM_W-1:0] vol_val;
  logic                    accept;
  logic                    launch;

  // Store and multiplier ports
  logic                    pa_we;
  logic [PA_W-1:0]         pa_waddr;
  logic [PA_W-1:0]         pa_raddr;
  logic [15:0]             pa_rdata;
  logic signed [15:0]      x;
  logic                    vol_we;
  logic [SUM_W-1:0]        vol_rdata;
  logic signed [MW-1:0]    mul_a;
  logic signed [MW-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != fbsv_pkg::S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  // Move a finished bit into the output register once it is free or being taken.
  assign launch       = (state == fbsv_pkg::S_FLUSH) && has_res && (!bit_valid || !bit_stall);

  // Clamp samples_per_symbol to [2, MAX]; derive the middle-third window.
  always_comb begin
    logic [9:0] sps_raw;
    sps_raw = 10'(sps_reg);
    if (sps_raw < 10'd2) begin
      sps_eff = SPS_W'(2);
    end else if (sps_raw > 10'(MAXS)) begin
      sps_eff = SPS_W'(MAXS);
    end else begin
      sps_eff = SPS_W'(sps_raw);
    end
  end

  assign sps11 = 11'(sps_eff);
  assign lo11  = fbsv_pkg::div3(sps11 + 11'd1);
  assign hi11  = fbsv_pkg::div3((sps11 << 1) + 11'd1);
  assign idx11 = 11'(sample_index);
  assign sym_end = (idx11 + 11'd1) >= sps11;

  assign middle_sum_next = middle_sum +
    ((idx11 >= lo11 && idx11 < hi11) ? SUM_W'(cur) : SUM_W'(0));
  assign symbol_sum_next = symbol_sum + SUM_W'(cur);

  assign x     = $signed(pa_rdata);
  assign v_cur = wq - mul_p;
  // Entries beyond the fill count have never been written and stand for zero.
  assign vol_val = (FILL_W'(mm_ridx) < vol_fill) ? $signed(vol_rdata) : SUM_W'(0);

  // Phase store: row is the symbol within the window, column the sample phase.
  assign pa_we    = (state == fbsv_pkg::S_TAKE);
  assign pa_waddr = PA_W'(PA_W'(symbol_count) * PA_W'(MAXS)) + PA_W'(sample_index);
  assign pa_raddr = PA_W'(PA_W'(row_k) * PA_W'(MAXS)) + PA_W'(ph_i);

  fbsv_ram #(
    .WIDTH(16),
    .DEPTH(PA_DEPTH)
  ) u_phase_ram (
    .clk  (clk),
    .we   (pa_we),
    .waddr(pa_waddr),
    .wdata(cur),
    .raddr(pa_raddr),
    .rdata(pa_rdata)
  );

  assign vol_we = (state == fbsv_pkg::S_VOLW);

  fbsv_ram #(
    .WIDTH(SUM_W),
    .DEPTH(LW)
  ) u_volume_ram (
    .clk  (clk),
    .we   (vol_we),
    .waddr(vol_index),
    .wdata(symbol_sum),
    .raddr(mm_cnt[VI_W-1:0]),
    .rdata(vol_rdata)
  );

  // Steer the shared multiplier by sequencer step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      fbsv_pkg::S_VSQ: begin
        mul_a = MW'(x);
        mul_b = MW'(x);
      end
      fbsv_pkg::S_VSS: begin
        mul_a = MW'(acc_s);
        mul_b = MW'(acc_s);
      end
      fbsv_pkg::S_ML: begin
        mul_a = $signed(MW'({sps11, 1'b0}));
        mul_b = MW'(middle_sum);
      end
      fbsv_pkg::S_MR: begin
        mul_a = MW'(vmax) + MW'(vmin);
        mul_b = $signed(MW'(hi11 - lo11));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  fbsv_mul #(
    .MW(MW)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sps_reg <= fbsv_pkg::SPS_RESET;
      inv_reg <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fbsv_pkg::REG_SPS: sps_reg <= cfg_data[6:0];
        fbsv_pkg::REG_INV: inv_reg <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Output register: load a finished bit, drop the beat once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_valid <= 1'b0;
    end else if (launch) begin
      bit_valid <= 1'b1;
      bit_res   <= res_bit;
    end else if (!bit_stall) begin
      bit_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fbsv_pkg::S_IDLE;
      pending      <= fbsv_pkg::ADJ_NONE;
      prev_sample  <= '0;
      two_take     <= 1'b0;
      has_res      <= 1'b0;
      sample_index <= '0;
      symbol_count <= '0;
      middle_sum   <= '0;
      symbol_sum   <= '0;
      vol_index    <= '0;
      vol_fill     <= '0;
      mm_rv        <= 1'b0;
    end else begin
      mm_rv <= 1'b0;

      unique case (state)
        fbsv_pkg::S_IDLE: begin
          if (accept) begin
            prev_sample <= sample;
            has_res     <= 1'b0;
            priority if (pending == fbsv_pkg::ADJ_SKIP) begin
              // drop this sample, only remember it
              pending <= fbsv_pkg::ADJ_NONE;
            end else if (pending == fbsv_pkg::ADJ_REPEAT) begin
              // process the previous sample again, then this one
              pending  <= fbsv_pkg::ADJ_NONE;
              cur      <= prev_sample;
              second   <= sample;
              two_take <= 1'b1;
              state    <= fbsv_pkg::S_TAKE;
            end else begin
              cur      <= sample;
              two_take <= 1'b0;
              state    <= fbsv_pkg::S_TAKE;
            end
          end
        end

        fbsv_pkg::S_TAKE: begin
          middle_sum <= middle_sum_next;
          symbol_sum <= symbol_sum_next;
          if (!sym_end) begin
            sample_index <= sample_index + 1'b1;
            if (two_take) begin
              cur      <= second;
              two_take <= 1'b0;
            end else begin
              state <= fbsv_pkg::S_FLUSH;
            end
          end else if (symbol_count == SC_W'(VW - 1)) begin
            // window of symbols complete: sweep the phases
            symbol_count <= '0;
            ph_i  <= '0;
            row_k <= '0;
            acc_s <= '0;
            acc_q <= '0;
            state <= fbsv_pkg::S_VRD;
          end else begin
            symbol_count <= symbol_count + 1'b1;
            state        <= fbsv_pkg::S_VOLW;
          end
        end

        fbsv_pkg::S_VRD: begin
          state <= fbsv_pkg::S_VSQ;
        end

        fbsv_pkg::S_VSQ: begin
          acc_s <= acc_s + S_W'(x);
          state <= fbsv_pkg::S_VACC;
        end

        fbsv_pkg::S_VACC: begin
          acc_q <= acc_q + mul_p[Q_W-1:0];
          if (row_k == SC_W'(VW - 1)) begin
            state <= fbsv_pkg::S_VSS;
          end else begin
            row_k <= row_k + 1'b1;
            state <= fbsv_pkg::S_VRD;
          end
        end

        fbsv_pkg::S_VSS: begin
          wq    <= $signed(PW'(acc_q) * PW'(VW));
          state <= fbsv_pkg::S_VVAR;
        end

        fbsv_pkg::S_VVAR: begin
          // first phase wins ties
          if (ph_i == '0 || v_cur < vmin_v) begin
            vmin_v     <= v_cur;
            best_phase <= ph_i;
          end
          if (11'(ph_i) == sps11 - 11'd1) begin
            state <= fbsv_pkg::S_VFIN;
          end else begin
            ph_i  <= ph_i + 1'b1;
            row_k <= '0;
            acc_s <= '0;
            acc_q <= '0;
            state <= fbsv_pkg::S_VRD;
          end
        end

        fbsv_pkg::S_VFIN: begin
          if (vmin_v > 0 && vmin_v <= LIMIT) begin
            if (best_phase != '0 && 11'(best_phase) < (sps11 >> 1)) begin
              pending <= fbsv_pkg::ADJ_SKIP;
            end else if (11'(best_phase) >= (sps11 >> 1) &&
                         11'(best_phase) < sps11 - 11'd1) begin
              pending <= fbsv_pkg::ADJ_REPEAT;
            end
          end
          state <= fbsv_pkg::S_VOLW;
        end

        fbsv_pkg::S_VOLW: begin
          vol_index <= (vol_index == VI_W'(LW - 1)) ? '0 : vol_index + 1'b1;
          if (vol_fill != FILL_W'(LW)) begin
            vol_fill <= vol_fill + 1'b1;
          end
          mm_cnt <= '0;
          state  <= fbsv_pkg::S_MM;
        end

        fbsv_pkg::S_MM: begin
          if (mm_cnt < (VI_W + 1)'(LW)) begin
            mm_cnt <= mm_cnt + 1'b1;
            mm_rv  <= 1'b1;
          end
          mm_ridx <= mm_cnt[VI_W-1:0];
          if (mm_rv) begin
            if (mm_ridx == '0) begin
              vmin <= vol_val;
              vmax <= vol_val;
            end else begin
              if (vol_val < vmin) vmin <= vol_val;
              if (vol_val > vmax) vmax <= vol_val;
            end
          end
          if (mm_cnt == (VI_W + 1)'(LW)) begin
            state <= fbsv_pkg::S_ML;
          end
        end

        fbsv_pkg::S_ML: begin
          state <= fbsv_pkg::S_MR;
        end

        fbsv_pkg::S_MR: begin
          lhs   <= mul_p;
          state <= fbsv_pkg::S_DEC;
        end

        fbsv_pkg::S_DEC: begin
          res_bit      <= (lhs > mul_p) ^ inv_reg;
          has_res      <= 1'b1;
          middle_sum   <= '0;
          symbol_sum   <= '0;
          sample_index <= '0;
          if (two_take) begin
            cur      <= second;
            two_take <= 1'b0;
            state    <= fbsv_pkg::S_TAKE;
          end else begin
            state <= fbsv_pkg::S_FLUSH;
          end
        end

        fbsv_pkg::S_FLUSH: begin
          if (!has_res) begin
            state <= fbsv_pkg::S_IDLE;
          end else if (launch) begin
            has_res <= 1'b0;
            state   <= fbsv_pkg::S_IDLE;
          end
        end

        default: begin
          state <= fbsv_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/fbsv_checker.sv =====
// Port-level checks for fsk_bit_slicer_variance_timing, bound to the top level.
// No package dependencies; sees the top level's ports only.
module fbsv_checker (
  input logic clk,
  input logic rst,
  input logic sample_valid,
  input logic sample_stall,
  input logic bit_valid,
  input logic bit_stall,
  input logic bit_res
);

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    bit_valid && bit_stall |=> bit_valid && $stable(bit_res))
    else $error("stalled output beat changed");

  // a bit only leaves once taken
  a_out_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(bit_valid) |-> $past(!bit_stall))
    else $error("output beat dropped without being taken");

  // a new bit is launched only from a busy step
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(bit_valid) |-> $past(sample_stall))
    else $error("output launched while idle");

  // reset empties the output register
  a_out_reset: assert property (@(posedge clk)
    rst |=> !bit_valid)
    else $error("output valid after reset");

endmodule

bind fsk_bit_slicer_variance_timing fbsv_checker u_fbsv_checker (.*);
